@@ sv/frame_reorder_jitter_buffer_top_defines.svh @@
// Assertion macros used by the jitter buffer top RTL.
`ifndef FRAME_REORDER_JITTER_BUFFER_TOP_DEFINES_SVH
`define FRAME_REORDER_JITTER_BUFFER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FRJB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FRJB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FRJB_ASSERT_IMP(lbl, ante, cons, msg)
`define FRJB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/frjb_pkg.sv @@
package frjb_pkg;
	localparam int CAPACITY_DEF = 64;

	typedef struct packed {
		logic [63:0] ext_id;
		logic [47:0] due;
		logic [31:0] tag;
		logic        key;
	} entry_t;

	localparam logic [1:0] MODE_PUSH   = 2'd0;
	localparam logic [1:0] MODE_POP    = 2'd1;
	localparam logic [1:0] MODE_RESYNC = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_BEFOREKEY = 3'd2;
	localparam logic [2:0] ST_LATE     = 3'd3;
	localparam logic [2:0] ST_POPPED   = 3'd4;
	localparam logic [2:0] ST_NONEDUE  = 3'd5;
	localparam logic [2:0] ST_RESYNCED = 3'd6;
	localparam logic [2:0] ST_CLEARED  = 3'd7;

	localparam logic [1:0] REG_SOFT = 2'd0;
	localparam logic [1:0] REG_HARD = 2'd1;
	localparam logic [1:0] REG_WFK  = 2'd2;
endpackage

@@ sv/frjb_ram.sv @@
module frjb_ram import frjb_pkg::*; #(
	parameter int AW = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);
	entry_t mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/frame_reorder_jitter_buffer_top.sv @@
// Frame reorder jitter buffer.
// Commands: pulse start with mode and the frame fields while busy is low;
// the command is taken at that edge. mode 0 pushes a frame, 1 pops the
// oldest frame if due by now_ms, 2 resyncs (drops all entries), 3 clears.
// Exactly one result follows: done is high for one cycle with status,
// popped frame fields, dropped/forced counts, ms_until_due and occupancy.
// The receiver cannot hold results off; busy falls in the cycle done rises,
// so a new command may be given then.
// Entries live in one single-port-write RAM ordered oldest first as a
// ring. A push scans the entries for its slot, shifts the later ones up
// through the single RAM write port, drops entries past the hard limit
// and makes the oldest entries past the soft limit due at once; a pop
// reads only the head entry, and resync and clear walk no entries.
// Configuration (soft_limit, hard_limit, wait_for_key) is to be written
// through cfg_we/cfg_index/cfg_wdata only while idle; the block does not
// enforce it. Reset empties the buffer at once, no clearing pass needed.
module frame_reorder_jitter_buffer_top import frjb_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [31:0]        frame_id,
	input  logic               is_key,
	input  logic [31:0]        frame_tag,
	input  logic [47:0]        play_at_ms,
	input  logic [47:0]        now_ms,
	output logic               done,
	output logic [2:0]         status,
	output logic [31:0]        out_frame_id,
	output logic [31:0]        out_tag,
	output logic               out_is_key,
	output logic [6:0]         dropped_count,
	output logic [6:0]         forced_count,
	output logic signed [31:0] ms_until_due,
	output logic [6:0]         occupancy,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_wdata
);
`include "frame_reorder_jitter_buffer_top_defines.svh"

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int CW = $clog2(CAPACITY + 2);
	localparam int HW = (CW > 8) ? CW : 8;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_DECIDE = 4'd2;
	localparam logic [3:0] S_SHIFT  = 4'd3;
	localparam logic [3:0] S_TRIM   = 4'd4;
	localparam logic [3:0] S_FORCE  = 4'd5;
	localparam logic [3:0] S_POPWT  = 4'd6;
	localparam logic [3:0] S_HEADRD = 4'd7;
	localparam logic [3:0] S_HEADWT = 4'd8;

	logic [3:0]    state_q;
	logic [6:0]    soft_q, hard_q;
	logic          wfk_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] head_q;
	logic [31:0]   anchor_raw_q;
	logic [63:0]   anchor_ext_q;
	logic          anchor_vld_q;
	logic [63:0]   last_out_q;
	logic          delivered_q;
	logic          started_q;

	logic [63:0]   ext_q;
	logic          key_q;
	logic [31:0]   tag_q;
	logic [47:0]   play_q;
	logic [47:0]   now_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic          dup_q;
	logic          pend_s1;
	logic [CW-1:0] idx_s1;

	logic          done_q;
	logic [2:0]    status_q;
	logic [31:0]   oid_q, otag_q;
	logic          okey_q;
	logic [6:0]    dropped_q, forced_q;
	logic [31:0]   until_q;

	logic          ram_we;
	logic [PW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata, new_entry;

	logic [31:0]   id_delta;
	logic [63:0]   ext_new;
	logic [7:0]    h8;
	logic [CW-1:0] h_eff;
	logic [CW-1:0] lim;
	logic [47:0]   due_diff;
	logic [31:0]   until_nxt;

	frjb_ram #(.AW(PW)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
			input logic [CW-1:0] l);
		return head + l[PW-1:0];
	endfunction

	always_comb begin
		id_delta = frame_id - anchor_raw_q;
		if (anchor_vld_q) begin
			ext_new = anchor_ext_q + {{32{id_delta[31]}}, id_delta};
		end else begin
			ext_new = {32'd0, frame_id};
		end
	end

	always_comb begin
		if (hard_q == 7'd0) begin
			h8 = (soft_q == 7'd0) ? 8'd1 : {soft_q, 1'b0};
		end else begin
			h8 = {1'b0, hard_q};
		end
		h_eff = (HW'(h8) > HW'(CAPACITY)) ? CW'(CAPACITY) : CW'(h8);
		lim = (HW'(count_q) > HW'(soft_q)) ? CW'(HW'(count_q) - HW'(soft_q)) : '0;
	end

	always_comb begin
		due_diff = ram_rdata.due - now_q;
		if (ram_rdata.due <= now_q) begin
			until_nxt = 32'd0;
		end else if (due_diff > 48'h7FFF_FFFF) begin
			until_nxt = 32'h7FFF_FFFF;
		end else begin
			until_nxt = due_diff[31:0];
		end
	end

	always_comb begin
		new_entry = '{ext_id: ext_q, due: play_q, tag: tag_q, key: key_q};
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, pos_q);
		ram_wdata = new_entry;
		ram_raddr = phys(head_q, idx_q);
		case (state_q)
			S_SHIFT: begin
				ram_raddr = phys(head_q, idx_q - CW'(1));
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = phys(head_q, idx_s1 + CW'(1));
					ram_wdata = ram_rdata;
				end else if (idx_q == pos_q) begin
					ram_we = 1'b1;
				end
			end
			S_FORCE: begin
				ram_waddr = phys(head_q, idx_s1);
				ram_wdata = ram_rdata;
				ram_wdata.due = '0;
				ram_we = pend_s1 && (ram_rdata.due != '0);
			end
			S_IDLE, S_HEADRD: begin
				ram_raddr = head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			soft_q       <= 7'd8;
			hard_q       <= 7'd16;
			wfk_q        <= 1'b1;
			count_q      <= '0;
			head_q       <= '0;
			anchor_raw_q <= '0;
			anchor_ext_q <= '0;
			anchor_vld_q <= 1'b0;
			last_out_q   <= '0;
			delivered_q  <= 1'b0;
			started_q    <= 1'b0;
			pend_s1      <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_SOFT: soft_q <= cfg_wdata;
					REG_HARD: hard_q <= cfg_wdata;
					REG_WFK:  wfk_q  <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q  <= is_key;
						tag_q  <= frame_tag;
						play_q <= play_at_ms;
						now_q  <= now_ms;
						oid_q  <= '0;
						otag_q <= '0;
						okey_q <= 1'b0;
						dropped_q <= '0;
						forced_q  <= '0;
						pend_s1   <= 1'b0;
						idx_q     <= '0;
						case (mode)
							MODE_PUSH: begin
								ext_q        <= ext_new;
								anchor_ext_q <= ext_new;
								anchor_raw_q <= frame_id;
								anchor_vld_q <= 1'b1;
								dup_q        <= 1'b0;
								pos_q        <= '0;
								state_q      <= (count_q == '0) ? S_DECIDE : S_SCAN;
							end
							MODE_POP: begin
								if (count_q == '0) begin
									status_q <= ST_NONEDUE;
									state_q  <= S_HEADRD;
								end else begin
									state_q <= S_POPWT;
								end
							end
							MODE_RESYNC: begin
								status_q  <= ST_RESYNCED;
								dropped_q <= 7'(count_q);
								count_q   <= '0;
								started_q <= !wfk_q;
								state_q   <= S_HEADRD;
							end
							default: begin
								status_q     <= ST_CLEARED;
								count_q      <= '0;
								head_q       <= '0;
								anchor_raw_q <= '0;
								anchor_ext_q <= '0;
								anchor_vld_q <= 1'b0;
								last_out_q   <= '0;
								delivered_q  <= 1'b0;
								started_q    <= !wfk_q;
								state_q      <= S_HEADRD;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (idx_q < count_q) begin
						pend_s1 <= 1'b1;
						idx_s1  <= idx_q;
						idx_q   <= idx_q + CW'(1);
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1) begin
						// list is sorted: first entry not below the new id is its slot
						if (ram_rdata.ext_id >= ext_q) begin
							pos_q   <= idx_s1;
							dup_q   <= (ram_rdata.ext_id == ext_q);
							pend_s1 <= 1'b0;
							state_q <= S_DECIDE;
						end else if (idx_s1 + CW'(1) == count_q) begin
							pos_q   <= count_q;
							pend_s1 <= 1'b0;
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (dup_q) begin
						status_q <= ST_DUP;
						state_q  <= S_HEADRD;
					end else if (!started_q && !key_q) begin
						status_q <= ST_BEFOREKEY;
						state_q  <= S_HEADRD;
					end else begin
						started_q <= 1'b1;
						if (delivered_q && ext_q <= last_out_q) begin
							status_q <= ST_LATE;
							state_q  <= S_HEADRD;
						end else begin
							status_q <= ST_STORED;
							idx_q    <= count_q;
							pend_s1  <= 1'b0;
							state_q  <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					// move entries up one slot from the tail down to the insert point
					if (idx_q > pos_q) begin
						pend_s1 <= 1'b1;
						idx_s1  <= idx_q - CW'(1);
						idx_q   <= idx_q - CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							count_q <= count_q + CW'(1);
							state_q <= S_TRIM;
						end
					end
				end
				S_TRIM: begin
					if (count_q > h_eff) begin
						dropped_q <= 7'(count_q - h_eff);
						head_q    <= phys(head_q, count_q - h_eff);
						count_q   <= h_eff;
					end
					idx_q   <= '0;
					pend_s1 <= 1'b0;
					state_q <= S_FORCE;
				end
				S_FORCE: begin
					if (idx_q < lim) begin
						pend_s1 <= 1'b1;
						idx_s1  <= idx_q;
						idx_q   <= idx_q + CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= S_HEADRD;
						end
					end
					if (pend_s1 && ram_rdata.due != '0) begin
						forced_q <= forced_q + 7'd1;
					end
				end
				S_POPWT: begin
					if (ram_rdata.due > now_q) begin
						status_q <= ST_NONEDUE;
					end else begin
						status_q    <= ST_POPPED;
						oid_q       <= ram_rdata.ext_id[31:0];
						otag_q      <= ram_rdata.tag;
						okey_q      <= ram_rdata.key;
						last_out_q  <= ram_rdata.ext_id;
						delivered_q <= 1'b1;
						head_q      <= head_q + PW'(1);
						count_q     <= count_q - CW'(1);
					end
					state_q <= S_HEADRD;
				end
				S_HEADRD: begin
					if (count_q == '0) begin
						until_q <= 32'hFFFF_FFFF;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_HEADWT;
					end
				end
				S_HEADWT: begin
					until_q <= until_nxt;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign out_frame_id  = oid_q;
	assign out_tag       = otag_q;
	assign out_is_key    = okey_q;
	assign dropped_count = dropped_q;
	assign forced_count  = forced_q;
	assign ms_until_due  = signed'(until_q);
	assign occupancy     = 7'(count_q);

	`FRJB_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE, "result shown while busy")
	`FRJB_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted command did not start")
	`FRJB_ASSERT_NXT(a_done_single, done_q, !done_q, "two results in consecutive cycles")
	`FRJB_ASSERT_IMP(a_pop_fields, done_q && status_q != ST_POPPED, oid_q == '0 && otag_q == '0, "frame fields set without pop")
	`FRJB_ASSERT_IMP(a_count_cap, state_q == S_IDLE, HW'(count_q) <= HW'(CAPACITY), "occupancy above capacity")
endmodule

@@ test/tb_top.sv @@
module tb_top;
	import frjb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		logic [1:0]  mode;
		logic [31:0] id;
		logic        key;
		logic [31:0] tag;
		logic [47:0] play;
		logic [47:0] now;
	} cmd_t;

	typedef struct {
		logic [2:0]         status;
		logic [31:0]        id;
		logic [31:0]        tag;
		logic               key;
		logic [6:0]         dropped;
		logic [6:0]         forced;
		logic signed [31:0] due_in;
		logic [6:0]         occ;
	} res_t;

	typedef struct {
		cmd_t       c;
		bit         chk;
		logic [2:0] st;
		logic [6:0] occ;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] mode = MODE_POP;
	logic [31:0] frame_id = '0;
	logic is_key = 0;
	logic [31:0] frame_tag = '0;
	logic [47:0] play_at_ms = '0;
	logic [47:0] now_ms = '0;
	logic done;
	logic [2:0] status;
	logic [31:0] out_frame_id;
	logic [31:0] out_tag;
	logic out_is_key;
	logic [6:0] dropped_count;
	logic [6:0] forced_count;
	logic signed [31:0] ms_until_due;
	logic [6:0] occupancy;
	logic cfg_we = 0;
	logic [1:0] cfg_index = REG_SOFT;
	logic [6:0] cfg_wdata = '0;

	frame_reorder_jitter_buffer_top dut (.*);

	always #5 clk = ~clk;

	// buffer model state
	logic [63:0] b_ext [DEPTH+1];
	logic [47:0] b_due [DEPTH+1];
	logic [31:0] b_tag [DEPTH+1];
	logic        b_key [DEPTH+1];
	int          b_cnt;
	logic [31:0] anc_raw;
	logic [63:0] anc_ext;
	bit          anc_ok;
	logic [63:0] last_out;
	bit          delivered;
	bit          started;
	logic [6:0]  soft_lim = 8;
	logic [6:0]  hard_lim = 16;
	bit          wfk = 1;

	res_t pending[$];
	int errors = 0;
	logic [47:0] clock_ms = 1000;
	logic [31:0] next_id = 32'hFFFF_FFF0;

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic void buffer_reset();
		b_cnt = 0;
		anc_raw = '0;
		anc_ext = '0;
		anc_ok = 0;
		last_out = '0;
		delivered = 0;
		started = !wfk;
	endfunction

	function automatic void drop_oldest(int n);
		if (n == 0 || n > b_cnt) return;
		for (int i = 0; i + n < b_cnt; i++) begin
			b_ext[i] = b_ext[i+n];
			b_due[i] = b_due[i+n];
			b_tag[i] = b_tag[i+n];
			b_key[i] = b_key[i+n];
		end
		b_cnt -= n;
	endfunction

	function automatic logic [63:0] unwrap_id(logic [31:0] raw);
		logic [31:0] d;
		if (!anc_ok) begin
			anc_ok = 1;
			anc_raw = raw;
			anc_ext = {32'd0, raw};
			return anc_ext;
		end
		d = raw - anc_raw;
		anc_ext = anc_ext + {{32{d[31]}}, d};
		anc_raw = raw;
		return anc_ext;
	endfunction

	function automatic res_t buffer_step(cmd_t c);
		res_t r;
		logic [63:0] ext;
		bit dup;
		int pos, h, lim;
		logic [47:0] left;
		r = '{default: '0};
		case (c.mode)
			MODE_PUSH: begin
				ext = unwrap_id(c.id);
				dup = 0;
				for (int i = 0; i < b_cnt; i++)
					if (b_ext[i] == ext) dup = 1;
				if (dup) begin
					r.status = ST_DUP;
				end else if (!started && !c.key) begin
					r.status = ST_BEFOREKEY;
				end else begin
					started = 1;
					if (delivered && ext <= last_out) begin
						r.status = ST_LATE;
					end else begin
						pos = 0;
						while (pos < b_cnt && b_ext[pos] < ext) pos++;
						for (int i = b_cnt; i > pos; i--) begin
							b_ext[i] = b_ext[i-1];
							b_due[i] = b_due[i-1];
							b_tag[i] = b_tag[i-1];
							b_key[i] = b_key[i-1];
						end
						b_ext[pos] = ext;
						b_due[pos] = c.play;
						b_tag[pos] = c.tag;
						b_key[pos] = c.key;
						b_cnt++;
						h = hard_lim;
						if (h == 0) begin
							h = 2 * soft_lim;
							if (h == 0) h = 1;
						end
						if (h > DEPTH) h = DEPTH;
						if (b_cnt > h) begin
							r.dropped = 7'(b_cnt - h);
							drop_oldest(b_cnt - h);
						end
						lim = b_cnt > soft_lim ? b_cnt - soft_lim : 0;
						for (int i = 0; i < lim; i++)
							if (b_due[i] != 0) begin
								b_due[i] = '0;
								r.forced++;
							end
						r.status = ST_STORED;
					end
				end
			end
			MODE_POP: begin
				if (b_cnt == 0 || b_due[0] > c.now) begin
					r.status = ST_NONEDUE;
				end else begin
					r.status = ST_POPPED;
					r.id = b_ext[0][31:0];
					r.tag = b_tag[0];
					r.key = b_key[0];
					last_out = b_ext[0];
					delivered = 1;
					drop_oldest(1);
				end
			end
			MODE_RESYNC: begin
				r.status = ST_RESYNCED;
				r.dropped = 7'(b_cnt);
				b_cnt = 0;
				started = !wfk;
			end
			default: begin
				r.status = ST_CLEARED;
				buffer_reset();
			end
		endcase
		if (b_cnt == 0) begin
			r.due_in = -1;
		end else if (b_due[0] <= c.now) begin
			r.due_in = 0;
		end else begin
			left = b_due[0] - c.now;
			r.due_in = left > 48'h7FFF_FFFF ? 32'h7FFF_FFFF : left[31:0];
		end
		r.occ = 7'(b_cnt);
		return r;
	endfunction

	// present one command and hold it until the transfer
	task automatic issue(cmd_t c, bit chk, logic [2:0] st, logic [6:0] occ);
		res_t r;
		int gap;
		start <= 1;
		mode <= c.mode;
		frame_id <= c.id;
		is_key <= c.key;
		frame_tag <= c.tag;
		play_at_ms <= c.play;
		now_ms <= c.now;
		do @(posedge clk); while (busy);
		r = buffer_step(c);
		if (chk) begin
			r.status = st;
			r.occ = occ;
		end
		pending.push_back(r);
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
			($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		start <= 0;
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_SOFT: soft_lim = val;
			REG_HARD: hard_lim = val;
			default: wfk = val[0];
		endcase
	endtask

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int sel;
		sel = $urandom_range(0, 99);
		c.mode = sel < 58 ? MODE_PUSH : sel < 95 ? MODE_POP : sel < 98 ? MODE_RESYNC : MODE_CLEAR;
		clock_ms += $urandom_range(0, 12);
		c.now = ($urandom_range(0, 49) == 0) ? 48'({$urandom, $urandom}) : clock_ms;
		c.tag = $urandom;
		c.key = $urandom_range(0, 3) == 0;
		c.play = ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom}) :
			clock_ms + $urandom_range(0, 60);
		if ($urandom_range(0, 19) == 0) begin
			c.id = $urandom;
		end else begin
			next_id += $urandom_range(0, 2);
			c.id = next_id - $urandom_range(0, 5);
		end
		return c;
	endfunction

	row_t rows[$] = '{
		'{'{MODE_POP, 0, 0, 0, 0, 0}, 1, ST_NONEDUE, 0},
		'{'{MODE_PUSH, 100, 0, 1, 0, 0}, 1, ST_BEFOREKEY, 0},
		'{'{MODE_PUSH, 101, 1, 32'hFFFF_FFFF, 0, 0}, 1, ST_STORED, 1},
		'{'{MODE_PUSH, 101, 1, 5, 0, 0}, 1, ST_DUP, 1},
		'{'{MODE_PUSH, 32'hFFFF_FFFF, 0, 6, 48'hFFFF_FFFF_FFFF, 0}, 0, 0, 0},
		'{'{MODE_POP, 0, 0, 0, 0, 0}, 1, ST_POPPED, 1},
		'{'{MODE_PUSH, 50, 1, 7, 10, 0}, 1, ST_LATE, 1},
		'{'{MODE_POP, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFE}, 0, 0, 0},
		'{'{MODE_POP, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF}, 1, ST_POPPED, 0},
		'{'{MODE_PUSH, 200, 1, 8, 0, 0}, 1, ST_LATE, 0},
		'{'{MODE_RESYNC, 0, 0, 0, 0, 0}, 1, ST_RESYNCED, 0},
		'{'{MODE_PUSH, 201, 0, 9, 0, 0}, 1, ST_BEFOREKEY, 0},
		'{'{MODE_CLEAR, 0, 0, 0, 0, 0}, 1, ST_CLEARED, 0},
		'{'{MODE_PUSH, 0, 1, 0, 48'h8000_0000_0000, 0}, 1, ST_STORED, 1},
		'{'{MODE_PUSH, 32'h8000_0000, 0, 1, 100, 5}, 0, 0, 0},
		'{'{MODE_PUSH, 3, 0, 2, 3000, 10}, 0, 0, 0},
		'{'{MODE_PUSH, 2, 1, 3, 20, 10}, 0, 0, 0},
		'{'{MODE_POP, 0, 0, 0, 0, 10}, 0, 0, 0},
		'{'{MODE_RESYNC, 0, 0, 0, 0, 0}, 1, ST_RESYNCED, 0}
	};

	// soft, hard, wait_for_key per phase
	logic [6:0] phase_cfg[6][3] = '{
		'{8, 16, 1}, '{0, 0, 0}, '{64, 64, 1}, '{127, 127, 0}, '{3, 5, 0}, '{4, 0, 1}
	};

	initial begin
		buffer_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) issue(rows[i].c, rows[i].chk, rows[i].st, rows[i].occ);
		start <= 0;
		foreach (phase_cfg[p]) begin
			write_reg(REG_SOFT, phase_cfg[p][0]);
			write_reg(REG_HARD, phase_cfg[p][1]);
			write_reg(REG_WFK, phase_cfg[p][2]);
			// a clear makes the new key policy take hold
			issue('{MODE_CLEAR, 0, 0, 0, 0, clock_ms}, 0, 0, 0);
			repeat (100) issue(rand_cmd(), 0, 0, 0);
			start <= 0;
		end
		while (pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		res_t w;
		if (done) begin
			if (pending.size() == 0) begin
				report("unexpected result", status, 0);
			end else begin
				w = pending.pop_front();
				if (status !== w.status) report("status", status, w.status);
				if (out_frame_id !== w.id) report("out_frame_id", out_frame_id, w.id);
				if (out_tag !== w.tag) report("out_tag", out_tag, w.tag);
				if (out_is_key !== w.key) report("out_is_key", out_is_key, w.key);
				if (dropped_count !== w.dropped) report("dropped_count", dropped_count, w.dropped);
				if (forced_count !== w.forced) report("forced_count", forced_count, w.forced);
				if (ms_until_due !== w.due_in) report("ms_until_due", ms_until_due, w.due_in);
				if (occupancy !== w.occ) report("occupancy", occupancy, w.occ);
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end
endmodule

@@ frame_reorder_jitter_buffer_top.f @@
+incdir+sv
sv/frjb_pkg.sv
sv/frjb_ram.sv
sv/frame_reorder_jitter_buffer_top.sv
test/tb_top.sv
